### hdl/drm_pkg.sv
package drm_pkg;

  localparam int MaxRegions = 16;
  localparam int CoordW     = 20;
  localparam int SizeW      = 19;
  localparam int InflW      = 10;
  localparam int CovW       = 17;
  localparam int ThrReset   = 49152;
  localparam int TouchGap   = 32;     // 16 units of pad on each of the two rectangles
  localparam int MinSize    = 16;
  localparam int SizeMax    = 524287;
  localparam int CoordMin   = -524288;
  localparam int AreaW      = 38;     // 19 x 19 bit product
  localparam int OutAreaW   = 42;
  localparam int RawW       = 32;
  localparam int CovOne     = 65536;
  localparam int DivSteps   = 16;
  localparam int DivCntW    = 5;
  localparam int RegionCntW = 5;
  localparam int MergedW    = 7;

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_MARK    = 2'd1,
    CMD_CONSUME = 2'd2,
    CMD_CLEAR   = 2'd3
  } drm_op_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [SizeW-1:0]         w;
    logic [SizeW-1:0]         h;
  } drm_rect_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EXEC,
    S_CONS_CHK,
    S_LOAD_I_RD,
    S_LOAD_I,
    S_J_RD,
    S_J_TEST,
    S_MRG_WR,
    S_MRG_MV,
    S_AREA_CHK,
    S_AREA_RD,
    S_AREA_OV,
    S_AREA_MUL,
    S_AREA_ACC,
    S_DIV_INIT,
    S_DIV,
    S_DECIDE,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_WAIT,
    S_FINISH
  } drm_state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic rd_i;
    logic load_i;
    logic rd_j;
    logic adv_j;
    logic adv_i;
    logic take_union;
    logic wr_union;
    logic mv_last;
    logic area_init;
    logic rd_k;
    logic area_ov;
    logic area_mul;
    logic area_acc;
    logic adv_k;
    logic div_init;
    logic div_step;
    logic decide;
    logic emit_load;
    logic finish;
  } drm_ctrl_t;

  // datapath -> controller
  typedef struct packed {
    drm_op_t op;
    logic    full_flag;
    logic    vp_empty;
    logic    touch;
    logic    j_last;
    logic    i_pen;
    logic    cnt_gt1;
    logic    cnt_gt2;
    logic    n_bad;
    logic    k_last;
    logic    div_done;
    logic    full_res;
    logic    out_taken;
  } drm_stat_t;

endpackage

### hdl/drm_ram.sv
module drm_ram #(
  parameter int WIDTH = 78,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/drm_ctrl.sv
module drm_ctrl import drm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  drm_stat_t stat,
  output drm_ctrl_t ctl
);

  drm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (in_valid) state_next = S_EXEC;
      S_EXEC:      state_next = (stat.op == CMD_CONSUME) ? S_CONS_CHK : S_IDLE;
      S_CONS_CHK: begin
        if (stat.full_flag || stat.vp_empty) state_next = S_DECIDE;
        else if (stat.cnt_gt1)               state_next = S_LOAD_I_RD;
        else                                 state_next = S_AREA_CHK;
      end
      S_LOAD_I_RD: state_next = S_LOAD_I;
      S_LOAD_I:    state_next = S_J_RD;
      S_J_RD:      state_next = S_J_TEST;
      S_J_TEST: begin
        if (stat.touch)       state_next = S_MRG_WR;
        else if (!stat.j_last) state_next = S_J_RD;
        else if (stat.i_pen)  state_next = S_AREA_CHK;
        else                  state_next = S_LOAD_I_RD;
      end
      S_MRG_WR:    state_next = S_MRG_MV;
      S_MRG_MV:    state_next = stat.cnt_gt2 ? S_LOAD_I_RD : S_AREA_CHK;
      S_AREA_CHK:  state_next = stat.n_bad ? S_DECIDE : S_AREA_RD;
      S_AREA_RD:   state_next = S_AREA_OV;
      S_AREA_OV:   state_next = S_AREA_MUL;
      S_AREA_MUL:  state_next = S_AREA_ACC;
      S_AREA_ACC:  state_next = stat.k_last ? S_DIV_INIT : S_AREA_RD;
      S_DIV_INIT:  state_next = S_DIV;
      S_DIV:       if (stat.div_done) state_next = S_DECIDE;
      S_DECIDE:    state_next = S_EMIT_RD;
      S_EMIT_RD:   state_next = S_EMIT_LD;
      S_EMIT_LD:   state_next = S_EMIT_WAIT;
      S_EMIT_WAIT: begin
        if (stat.out_taken) begin
          state_next = (stat.full_res || stat.k_last) ? S_FINISH : S_EMIT_RD;
        end
      end
      S_FINISH:    state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall    = 1'b0;
        ctl.capture = in_valid;
      end
      S_EXEC:      ctl.exec = 1'b1;
      S_CONS_CHK:  ;
      S_LOAD_I_RD: ctl.rd_i = 1'b1;
      S_LOAD_I:    ctl.load_i = 1'b1;
      S_J_RD:      ctl.rd_j = 1'b1;
      S_J_TEST: begin
        if (stat.touch)       ctl.take_union = 1'b1;
        else if (!stat.j_last) ctl.adv_j = 1'b1;
        else if (!stat.i_pen) ctl.adv_i = 1'b1;
      end
      S_MRG_WR:    ctl.wr_union = 1'b1;
      S_MRG_MV:    ctl.mv_last = 1'b1;
      S_AREA_CHK:  ctl.area_init = 1'b1;
      S_AREA_RD:   ctl.rd_k = 1'b1;
      S_AREA_OV:   ctl.area_ov = 1'b1;
      S_AREA_MUL:  ctl.area_mul = 1'b1;
      S_AREA_ACC: begin
        ctl.area_acc = 1'b1;
        ctl.adv_k    = !stat.k_last;
      end
      S_DIV_INIT:  ctl.div_init = 1'b1;
      S_DIV:       ctl.div_step = !stat.div_done;
      S_DECIDE:    ctl.decide = 1'b1;
      S_EMIT_RD:   ctl.rd_k = 1'b1;
      S_EMIT_LD:   ctl.emit_load = 1'b1;
      S_EMIT_WAIT: ctl.adv_k = stat.out_taken && !(stat.full_res || stat.k_last);
      S_FINISH:    ctl.finish = 1'b1;
      default:     ;
    endcase
  end

endmodule

### hdl/drm_dp.sv
module drm_dp import drm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CovW-1:0]          cfg_data,
  input  logic [1:0]               cmd,
  input  logic signed [CoordW-1:0] x,
  input  logic signed [CoordW-1:0] y,
  input  logic [SizeW-1:0]         width,
  input  logic [SizeW-1:0]         height,
  input  logic [InflW-1:0]         inflate,
  input  drm_ctrl_t                ctl,
  output drm_stat_t                stat,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [CoordW-1:0] region_x,
  output logic signed [CoordW-1:0] region_y,
  output logic [SizeW-1:0]         region_w,
  output logic [SizeW-1:0]         region_h,
  output logic                     full_dirty,
  output logic [RegionCntW-1:0]    region_count,
  output logic [MergedW-1:0]       merged_count,
  output logic [RawW-1:0]          raw_add_count,
  output logic [OutAreaW-1:0]      dirty_area,
  output logic [OutAreaW-1:0]      viewport_area,
  output logic [CovW-1:0]          coverage,
  output logic                     last
);

  localparam int Depth = 4 * MaxRegions;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = $clog2(Depth + 1);
  localparam int AccW  = AreaW + $clog2(MaxRegions + 1);
  localparam int RemW  = AreaW + 1;

  typedef struct packed {
    logic signed [CoordW-1:0] lo;
    logic [SizeW-1:0]         len;
  } drm_span_t;

  function automatic logic [SizeW-1:0] clamp_size(input logic signed [22:0] v);
    if (v > SizeMax) return '1;
    return v[SizeW-1:0];
  endfunction

  function automatic logic touch_1d(input logic signed [CoordW-1:0] a0,
                                    input logic [SizeW-1:0] aw,
                                    input logic signed [CoordW-1:0] b0,
                                    input logic [SizeW-1:0] bw);
    logic signed [21:0] a_lo, b_lo, a_hi, b_hi;
    a_lo = 22'(a0);
    b_lo = 22'(b0);
    a_hi = a_lo + $signed({3'b000, aw}) + 22'(TouchGap);
    b_hi = b_lo + $signed({3'b000, bw}) + 22'(TouchGap);
    return (a_lo < b_hi) && (b_lo < a_hi);
  endfunction

  function automatic drm_span_t span_union(input logic signed [CoordW-1:0] a0,
                                           input logic [SizeW-1:0] aw,
                                           input logic signed [CoordW-1:0] b0,
                                           input logic [SizeW-1:0] bw);
    logic signed [21:0] a_hi, b_hi, hi;
    drm_span_t          s;
    a_hi   = 22'(a0) + $signed({3'b000, aw});
    b_hi   = 22'(b0) + $signed({3'b000, bw});
    hi     = (a_hi > b_hi) ? a_hi : b_hi;
    s.lo   = (a0 < b0) ? a0 : b0;
    s.len  = clamp_size(23'(hi) - 23'(s.lo));
    return s;
  endfunction

  function automatic logic [SizeW-1:0] overlap_1d(input logic signed [CoordW-1:0] a0,
                                                  input logic [SizeW-1:0] aw,
                                                  input logic signed [CoordW-1:0] b0,
                                                  input logic [SizeW-1:0] bw);
    logic signed [21:0] a_hi, b_hi, lo, hi;
    a_hi = 22'(a0) + $signed({3'b000, aw});
    b_hi = 22'(b0) + $signed({3'b000, bw});
    lo   = (a0 > b0) ? 22'(a0) : 22'(b0);
    hi   = (a_hi < b_hi) ? a_hi : b_hi;
    return (hi > lo) ? SizeW'(hi - lo) : '0;
  endfunction

  // captured item
  drm_op_t                  op;
  logic signed [CoordW-1:0] vx, vy;
  logic [SizeW-1:0]         vw, vh;
  logic [InflW-1:0]         vinf;

  logic [CovW-1:0]     thr;
  logic [CW-1:0]       cnt;
  logic                full_flag;
  logic [RawW-1:0]     raw_count;
  logic [AW-1:0]       i, j, k;
  logic [CW-1:0]       merged;
  drm_rect_t           cur;
  logic [SizeW-1:0]    ov_w, ov_h;
  logic [AreaW-1:0]    prod;
  logic [AccW-1:0]     acc;
  logic [AreaW-1:0]    varea;
  logic [RemW-1:0]     rem;
  logic [CovW-1:0]     cov;
  logic [DivCntW-1:0]  div_cnt;
  logic                full_res;

  drm_rect_t       rdata, wdata, add_rect;
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [CW-1:0]   cnt_m1;
  logic            vp_empty, add_nonempty;
  drm_span_t       ux, uy;
  logic [RemW-1:0] div_t;

  // add: inflate, clamp the top-left corner, hold sizes in [16, 524287]
  logic signed [20:0] add_l, add_t;
  logic signed [21:0] add_r, add_b;
  logic [SizeW-1:0]   add_w, add_h;

  always_comb begin
    add_l = 21'(vx) - $signed({11'b0, vinf});
    add_t = 21'(vy) - $signed({11'b0, vinf});
    add_r = 22'(vx) + $signed({3'b000, vw}) + $signed({12'b0, vinf});
    add_b = 22'(vy) + $signed({3'b000, vh}) + $signed({12'b0, vinf});
    if (add_l < CoordMin) add_l = 21'(CoordMin);
    if (add_t < CoordMin) add_t = 21'(CoordMin);
    add_w = clamp_size(23'(add_r) - 23'(add_l));
    add_h = clamp_size(23'(add_b) - 23'(add_t));
    if (add_w < SizeW'(MinSize)) add_w = SizeW'(MinSize);
    if (add_h < SizeW'(MinSize)) add_h = SizeW'(MinSize);
    add_rect.x = add_l[CoordW-1:0];
    add_rect.y = add_t[CoordW-1:0];
    add_rect.w = add_w;
    add_rect.h = add_h;
  end

  assign cnt_m1       = cnt - 1'b1;
  assign vp_empty     = (vw == '0) || (vh == '0);
  assign add_nonempty = !vp_empty;
  assign ux           = span_union(cur.x, cur.w, rdata.x, rdata.w);
  assign uy           = span_union(cur.y, cur.h, rdata.y, rdata.h);
  assign div_t        = {rem[RemW-2:0], 1'b0};
  assign cfg_ready    = 1'b1;

  always_comb begin
    we    = 1'b0;
    waddr = i;
    wdata = cur;
    if (ctl.exec && op == CMD_ADD && add_nonempty && !full_flag &&
        cnt < CW'(Depth)) begin
      we    = 1'b1;
      waddr = AW'(cnt);
      wdata = add_rect;
    end else if (ctl.wr_union) begin
      we    = 1'b1;
      waddr = i;
      wdata = cur;
    end else if (ctl.mv_last) begin
      we    = 1'b1;
      waddr = j;
      wdata = rdata;
    end
  end

  always_comb begin
    priority if (ctl.rd_i)     raddr = i;
    else if (ctl.rd_j)         raddr = j;
    else if (ctl.wr_union)     raddr = AW'(cnt_m1);
    else                       raddr = k;
  end

  drm_ram #(.WIDTH($bits(drm_rect_t)), .DEPTH(Depth)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    stat.op        = op;
    stat.full_flag = full_flag;
    stat.vp_empty  = vp_empty;
    stat.touch     = touch_1d(cur.x, cur.w, rdata.x, rdata.w) &&
                     touch_1d(cur.y, cur.h, rdata.y, rdata.h);
    stat.j_last    = CW'(j) == cnt_m1;
    stat.i_pen     = CW'(i) == (cnt - CW'(2));
    stat.cnt_gt1   = cnt > CW'(1);
    stat.cnt_gt2   = cnt > CW'(2);
    stat.n_bad     = (cnt > CW'(MaxRegions)) || (cnt == '0);
    stat.k_last    = CW'(k) == cnt_m1;
    stat.div_done  = div_cnt == DivCntW'(DivSteps);
    stat.full_res  = full_res;
    stat.out_taken = out_valid && !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= CovW'(ThrReset);
    end else if (cfg_valid) begin
      thr <= cfg_data;
    end
  end

  // control-side state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      full_flag <= 1'b0;
      raw_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.exec) begin
        unique case (op)
          CMD_ADD: begin
            if (add_nonempty) begin
              raw_count <= raw_count + 1'b1;
              if (!full_flag) begin
                if (cnt < CW'(Depth)) begin
                  cnt <= cnt + 1'b1;
                end else begin
                  full_flag <= 1'b1;
                  cnt       <= '0;
                end
              end
            end
          end
          CMD_MARK: begin
            full_flag <= 1'b1;
            cnt       <= '0;
            raw_count <= raw_count + 1'b1;
          end
          CMD_CLEAR: begin
            full_flag <= 1'b0;
            cnt       <= '0;
            raw_count <= '0;
          end
          CMD_CONSUME: ;
          default: ;
        endcase
      end
      if (ctl.mv_last) cnt <= cnt_m1;
      if (ctl.finish) begin
        cnt       <= '0;
        full_flag <= 1'b0;
        raw_count <= '0;
      end
      if (ctl.emit_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op   <= drm_op_t'(cmd);
      vx   <= x;
      vy   <= y;
      vw   <= width;
      vh   <= height;
      vinf <= inflate;
    end
    if (ctl.exec) begin
      merged <= '0;
      i      <= '0;
      varea  <= AreaW'(vw) * AreaW'(vh);
    end
    if (ctl.load_i) begin
      cur <= rdata;
      j   <= i + 1'b1;
    end
    if (ctl.adv_j) j <= j + 1'b1;
    if (ctl.adv_i) i <= i + 1'b1;
    if (ctl.take_union) begin
      cur.x <= ux.lo;
      cur.w <= ux.len;
      cur.y <= uy.lo;
      cur.h <= uy.len;
    end
    if (ctl.mv_last) begin
      i      <= '0;
      merged <= merged + 1'b1;
    end
    if (ctl.area_init) begin
      k   <= '0;
      acc <= '0;
    end
    if (ctl.area_ov) begin
      ov_w <= overlap_1d(rdata.x, rdata.w, vx, vw);
      ov_h <= overlap_1d(rdata.y, rdata.h, vy, vh);
    end
    if (ctl.area_mul) prod <= AreaW'(ov_w) * AreaW'(ov_h);
    if (ctl.area_acc) acc <= acc + AccW'(prod);
    if (ctl.adv_k) k <= k + 1'b1;
    if (ctl.div_init) begin
      if (acc >= AccW'(varea)) begin
        cov     <= CovW'(CovOne);
        div_cnt <= DivCntW'(DivSteps);
      end else begin
        cov     <= '0;
        rem     <= RemW'(acc);
        div_cnt <= '0;
      end
    end
    if (ctl.div_step) begin
      if (div_t >= RemW'(varea)) begin
        rem <= div_t - RemW'(varea);
        cov <= {cov[CovW-2:0], 1'b1};
      end else begin
        rem <= div_t;
        cov <= {cov[CovW-2:0], 1'b0};
      end
      div_cnt <= div_cnt + 1'b1;
    end
    if (ctl.decide) begin
      full_res <= full_flag || vp_empty || stat.n_bad || (cov >= thr);
      k        <= '0;
    end
    if (ctl.emit_load) begin
      merged_count  <= MergedW'(merged);
      raw_add_count <= raw_count;
      viewport_area <= OutAreaW'(varea);
      if (full_res) begin
        region_x     <= vp_empty ? '0 : vx;
        region_y     <= vp_empty ? '0 : vy;
        region_w     <= vp_empty ? '0 : vw;
        region_h     <= vp_empty ? '0 : vh;
        full_dirty   <= 1'b1;
        region_count <= RegionCntW'(1);
        dirty_area   <= OutAreaW'(varea);
        coverage     <= CovW'(CovOne);
        last         <= 1'b1;
      end else begin
        region_x     <= rdata.x;
        region_y     <= rdata.y;
        region_w     <= rdata.w;
        region_h     <= rdata.h;
        full_dirty   <= 1'b0;
        region_count <= RegionCntW'(cnt);
        dirty_area   <= OutAreaW'(acc);
        coverage     <= cov;
        last         <= stat.k_last;
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= CW'(Depth))
    else $error("store count beyond depth");

  a_full_empty: assert property (@(posedge clk) disable iff (rst) full_flag |-> cnt == '0)
    else $error("rectangles held while full dirty");

  a_full_single: assert property (@(posedge clk) disable iff (rst)
      out_valid && full_dirty |-> last && region_count == RegionCntW'(1))
    else $error("full-dirty result not single");

endmodule

### hdl/dirty_rect_merge_tracker.sv
// Channel  Handshake               Payload
// cfg      cfg_valid / cfg_ready   cfg_data = coverage_threshold (Q1.16)
// in       in_valid / in_stall     cmd, x, y, width, height, inflate
// out      out_valid / out_stall   region_x..h, full_dirty, counts, areas, coverage, last
//
// Add, mark and clear are captured in the idle state and update the store in the exec state.
// Consume: capture and check, then the merge scan: load each first entry, read and
//   test each pair, and write back and move the last entry after every merge, after
//   which the scan restarts at the first entry; then per region a read, overlap,
//   multiply and accumulate for the area sum, the coverage divide, decide, a read,
//   load and wait per result plus stall time, and finish.
// The rectangle store is one single-port-read RAM; it sets the pair test rate.
// Reset (rst, synchronous) empties the store, clears full-dirty and the raw count,
//   and loads the threshold with 0.75.
// in_stall is high from the cycle after capture until the block is idle again:
//   after exec for add, mark and clear, after finish for a consume.
module dirty_rect_merge_tracker import drm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CovW-1:0]          cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               cmd,
  input  logic signed [CoordW-1:0] x,
  input  logic signed [CoordW-1:0] y,
  input  logic [SizeW-1:0]         width,
  input  logic [SizeW-1:0]         height,
  input  logic [InflW-1:0]         inflate,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [CoordW-1:0] region_x,
  output logic signed [CoordW-1:0] region_y,
  output logic [SizeW-1:0]         region_w,
  output logic [SizeW-1:0]         region_h,
  output logic                     full_dirty,
  output logic [RegionCntW-1:0]    region_count,
  output logic [MergedW-1:0]       merged_count,
  output logic [RawW-1:0]          raw_add_count,
  output logic [OutAreaW-1:0]      dirty_area,
  output logic [OutAreaW-1:0]      viewport_area,
  output logic [CovW-1:0]          coverage,
  output logic                     last
);

  drm_ctrl_t ctl;
  drm_stat_t stat;

  // sequencer: walks consume through merge, area, divide and emit
  drm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  // store, merge unit, area accumulator, divider, output register
  drm_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .x             (x),
    .y             (y),
    .width         (width),
    .height        (height),
    .inflate       (inflate),
    .ctl           (ctl),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .region_x      (region_x),
    .region_y      (region_y),
    .region_w      (region_w),
    .region_h      (region_h),
    .full_dirty    (full_dirty),
    .region_count  (region_count),
    .merged_count  (merged_count),
    .raw_add_count (raw_add_count),
    .dirty_area    (dirty_area),
    .viewport_area (viewport_area),
    .coverage      (coverage),
    .last          (last)
  );

endmodule

### dv/drm_checker.sv
`timescale 1ns / 100ps

module drm_checker import drm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CovW-1:0]          cfg_data,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [1:0]               cmd,
  input  logic signed [CoordW-1:0] x,
  input  logic signed [CoordW-1:0] y,
  input  logic [SizeW-1:0]         width,
  input  logic [SizeW-1:0]         height,
  input  logic [InflW-1:0]         inflate,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [CoordW-1:0] region_x,
  input  logic signed [CoordW-1:0] region_y,
  input  logic [SizeW-1:0]         region_w,
  input  logic [SizeW-1:0]         region_h,
  input  logic                     full_dirty,
  input  logic [RegionCntW-1:0]    region_count,
  input  logic [MergedW-1:0]       merged_count,
  input  logic [RawW-1:0]          raw_add_count,
  input  logic [OutAreaW-1:0]      dirty_area,
  input  logic [OutAreaW-1:0]      viewport_area,
  input  logic [CovW-1:0]          coverage,
  input  logic                     last,
  output int                       fail_count,
  output int                       outstanding,
  output int                       results_seen
);

  localparam int Depth = 4 * MaxRegions;
  localparam longint Pad = 16;

  typedef struct {
    logic signed [CoordW-1:0] rx;
    logic signed [CoordW-1:0] ry;
    logic [SizeW-1:0]         rw;
    logic [SizeW-1:0]         rh;
    logic                     full;
    logic [RegionCntW-1:0]    cnt;
    logic [MergedW-1:0]       merged;
    logic [RawW-1:0]          raw;
    logic [OutAreaW-1:0]      darea;
    logic [OutAreaW-1:0]      varea;
    logic [CovW-1:0]          cov;
    logic                     lst;
  } region_result_t;

  region_result_t frame_q[$];

  logic [CovW-1:0] threshold;
  longint          rect_x[Depth];
  longint          rect_y[Depth];
  longint          rect_w[Depth];
  longint          rect_h[Depth];
  int              rect_cnt;
  logic            all_dirty;
  logic [RawW-1:0] raw_cnt;

  function automatic longint sat_size(longint s);
    return s > SizeMax ? longint'(SizeMax) : s;
  endfunction

  function automatic bit near(int a, int b);
    return rect_x[a] - Pad < rect_x[b] + rect_w[b] + Pad &&
           rect_x[b] - Pad < rect_x[a] + rect_w[a] + Pad &&
           rect_y[a] - Pad < rect_y[b] + rect_h[b] + Pad &&
           rect_y[b] - Pad < rect_y[a] + rect_h[a] + Pad;
  endfunction

  function automatic longint span(longint a0, longint a1, longint b0, longint b1);
    longint lo, hi;
    lo = a0 > b0 ? a0 : b0;
    hi = a1 < b1 ? a1 : b1;
    return hi > lo ? hi - lo : 0;
  endfunction

  // first touching pair in scan order, union into i, last entry moves to j
  task automatic coalesce();
    bit again;
    longint l, t, r, b;
    again = 1;
    while (again && rect_cnt > 1) begin
      again = 0;
      for (int i = 0; i < rect_cnt && !again; i++) begin
        for (int j = i + 1; j < rect_cnt; j++) begin
          if (near(i, j)) begin
            l = rect_x[i] < rect_x[j] ? rect_x[i] : rect_x[j];
            t = rect_y[i] < rect_y[j] ? rect_y[i] : rect_y[j];
            r = rect_x[i] + rect_w[i];
            if (rect_x[j] + rect_w[j] > r) r = rect_x[j] + rect_w[j];
            b = rect_y[i] + rect_h[i];
            if (rect_y[j] + rect_h[j] > b) b = rect_y[j] + rect_h[j];
            rect_x[i] = l;
            rect_y[i] = t;
            rect_w[i] = sat_size(r - l);
            rect_h[i] = sat_size(b - t);
            rect_cnt--;
            rect_x[j] = rect_x[rect_cnt];
            rect_y[j] = rect_y[rect_cnt];
            rect_w[j] = rect_w[rect_cnt];
            rect_h[j] = rect_h[rect_cnt];
            again = 1;
            break;
          end
        end
      end
    end
  endtask

  task automatic predict_frame(longint vx, longint vy, longint vw, longint vh);
    region_result_t res;
    bit   vp_empty, full;
    int   merged, n;
    longint unsigned varea, darea, cov;
    vp_empty = (vw == 0 || vh == 0);
    varea = vw * vh;
    darea = 0;
    cov = CovOne;
    merged = 0;
    n = 0;
    full = 0;
    if (all_dirty || vp_empty) begin
      full = 1;
    end else begin
      n = rect_cnt;
      coalesce();
      merged = n - rect_cnt;
      n = rect_cnt;
      if (n > MaxRegions || n == 0) begin
        full = 1;
      end else begin
        for (int i = 0; i < n; i++)
          darea += span(rect_x[i], rect_x[i] + rect_w[i], vx, vx + vw) *
                   span(rect_y[i], rect_y[i] + rect_h[i], vy, vy + vh);
        cov = (darea << 16) / varea;
        if (cov > CovOne) cov = CovOne;
        if (cov >= threshold) full = 1;
      end
    end
    res.merged = MergedW'(merged);
    res.raw = raw_cnt;
    res.varea = OutAreaW'(varea);
    if (full) begin
      res.rx = vp_empty ? '0 : CoordW'(vx);
      res.ry = vp_empty ? '0 : CoordW'(vy);
      res.rw = vp_empty ? '0 : SizeW'(vw);
      res.rh = vp_empty ? '0 : SizeW'(vh);
      res.full = 1'b1;
      res.cnt = RegionCntW'(1);
      res.darea = OutAreaW'(varea);
      res.cov = CovW'(CovOne);
      res.lst = 1'b1;
      frame_q = {frame_q, res};
    end else begin
      for (int i = 0; i < n; i++) begin
        res.rx = CoordW'(rect_x[i]);
        res.ry = CoordW'(rect_y[i]);
        res.rw = SizeW'(rect_w[i]);
        res.rh = SizeW'(rect_h[i]);
        res.full = 1'b0;
        res.cnt = RegionCntW'(n);
        res.darea = OutAreaW'(darea);
        res.cov = CovW'(cov);
        res.lst = (i == n - 1);
        frame_q = {frame_q, res};
      end
    end
    rect_cnt = 0;
    all_dirty = 0;
    raw_cnt = 0;
  endtask

  task automatic track_item();
    longint vx, vy, vw, vh, inf, l, t, nw, nh;
    vx = x;
    vy = y;
    vw = width;
    vh = height;
    inf = inflate;
    case (drm_op_t'(cmd))
      CMD_ADD: begin
        if (vw != 0 && vh != 0) begin
          raw_cnt++;
          if (!all_dirty) begin
            if (rect_cnt >= Depth) begin
              all_dirty = 1;
              rect_cnt = 0;
            end else begin
              l = vx - inf;
              t = vy - inf;
              if (l < CoordMin) l = CoordMin;
              if (t < CoordMin) t = CoordMin;
              nw = sat_size(vx + vw + inf - l);
              nh = sat_size(vy + vh + inf - t);
              if (nw < MinSize) nw = MinSize;
              if (nh < MinSize) nh = MinSize;
              rect_x[rect_cnt] = l;
              rect_y[rect_cnt] = t;
              rect_w[rect_cnt] = nw;
              rect_h[rect_cnt] = nh;
              rect_cnt++;
            end
          end
        end
      end
      CMD_MARK: begin
        all_dirty = 1;
        rect_cnt = 0;
        raw_cnt++;
      end
      CMD_CLEAR: begin
        all_dirty = 0;
        rect_cnt = 0;
        raw_cnt = 0;
      end
      default: predict_frame(vx, vy, vw, vh);
    endcase
  endtask

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    fail_count++;
    if (fail_count <= 30)
      $display("%0t ns: region %0d field %s got %0h, want %0h",
               $time, results_seen, field, got, want);
  endtask

  task automatic check_region();
    region_result_t e;
    if (frame_q.size() == 0) begin
      report("unexpected", 1, 0);
      return;
    end
    e = frame_q.pop_front();
    if (region_x !== e.rx) report("region_x", region_x, e.rx);
    if (region_y !== e.ry) report("region_y", region_y, e.ry);
    if (region_w !== e.rw) report("region_w", region_w, e.rw);
    if (region_h !== e.rh) report("region_h", region_h, e.rh);
    if (full_dirty !== e.full) report("full_dirty", full_dirty, e.full);
    if (region_count !== e.cnt) report("region_count", region_count, e.cnt);
    if (merged_count !== e.merged) report("merged_count", merged_count, e.merged);
    if (raw_add_count !== e.raw) report("raw_add_count", raw_add_count, e.raw);
    if (dirty_area !== e.darea) report("dirty_area", dirty_area, e.darea);
    if (viewport_area !== e.varea) report("viewport_area", viewport_area, e.varea);
    if (coverage !== e.cov) report("coverage", coverage, e.cov);
    if (last !== e.lst) report("last", last, e.lst);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      threshold = CovW'(ThrReset);
      rect_cnt = 0;
      all_dirty = 0;
      raw_cnt = 0;
      fail_count = 0;
      results_seen = 0;
      frame_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) threshold = cfg_data;
      if (in_valid && !in_stall) track_item();
      if (out_valid && !out_stall) begin
        check_region();
        results_seen++;
      end
    end
    outstanding = frame_q.size();
  end

endmodule

### dv/dirty_rect_merge_tracker_tb.sv
`timescale 1ns / 100ps

module dirty_rect_merge_tracker_tb;
  import drm_pkg::*;

  localparam int CycleLimit = 3000000;

  logic                     clk = 0;
  logic                     rst = 1;
  logic                     cfg_valid = 0;
  logic [CovW-1:0]          cfg_data = '0;
  logic                     in_valid = 0;
  logic [1:0]               cmd = CMD_CLEAR;
  logic signed [CoordW-1:0] x = '0;
  logic signed [CoordW-1:0] y = '0;
  logic [SizeW-1:0]         width = '0;
  logic [SizeW-1:0]         height = '0;
  logic [InflW-1:0]         inflate = '0;
  logic                     out_stall = 0;

  logic                     cfg_ready, in_stall, out_valid;
  logic signed [CoordW-1:0] region_x, region_y;
  logic [SizeW-1:0]         region_w, region_h;
  logic                     full_dirty, last;
  logic [RegionCntW-1:0]    region_count;
  logic [MergedW-1:0]       merged_count;
  logic [RawW-1:0]          raw_add_count;
  logic [OutAreaW-1:0]      dirty_area, viewport_area;
  logic [CovW-1:0]          coverage;

  int fail_count, outstanding, results_seen;
  int send_idle_pct, stall_pct;   // sender idle and receiver stall odds per cycle, in percent
  int items_sent;
  int cycles;

  dirty_rect_merge_tracker uut (.*);

  drm_checker chk (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver stall, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("dirty_rect_merge_tracker verification failed");
      $finish;
    end
  end

  function automatic int clamp20(int v);
    if (v < CoordMin) return CoordMin;
    if (v > 524287) return 524287;
    return v;
  endfunction

  // one input transfer; idles before it at the current phase's odds
  task automatic send(drm_op_t op, int px, int py, int pw, int ph, int pinf);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    cmd <= op;
    x <= px[CoordW-1:0];
    y <= py[CoordW-1:0];
    width <= pw[SizeW-1:0];
    height <= ph[SizeW-1:0];
    inflate <= pinf[InflW-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // drain all results, then let a trailing add/mark/clear settle
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_threshold(int v);
    cfg_valid <= 1;
    cfg_data <= v[CovW-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  // directed: edges, saturation, every command, each special case
  task automatic directed_items();
    send(CMD_CONSUME, 0, 0, 1600, 1600, 0);                 // nothing stored
    send(CMD_ADD, 100, 100, 0, 50, 5);                      // empty add, ignored
    send(CMD_ADD, CoordMin, CoordMin, 524287, 524287, 1023); // left/top saturate, size sat
    send(CMD_ADD, 524287, 524287, 1, 1, 0);                 // min size clamp
    send(CMD_CONSUME, CoordMin, CoordMin, 524287, 524287, 1023);
    send(CMD_ADD, 0, 0, 160, 160, 0);
    send(CMD_ADD, 190, 0, 160, 160, 0);                     // within pad, merges
    send(CMD_ADD, 0, 400, 32, 32, 0);                       // well apart, stays separate
    send(CMD_ADD, 2000, 2000, 3, 3, 0);
    send(CMD_CONSUME, -100, -100, 40000, 40000, 0);
    send(CMD_MARK, 0, 0, 0, 0, 0);
    send(CMD_ADD, 10, 10, 10, 10, 1);                       // counted, not stored
    send(CMD_CONSUME, -5, -7, 300, 200, 0);
    send(CMD_ADD, 10, 10, 10, 10, 1);
    send(CMD_CONSUME, 5, 5, 0, 100, 0);                     // empty viewport
    send(CMD_ADD, 10, 10, 10, 10, 1);
    send(CMD_CLEAR, 0, 0, 0, 0, 0);
    send(CMD_CONSUME, 0, 0, 100, 100, 0);
    send(CMD_ADD, 0, 0, 1600, 1600, 0);                     // high coverage
    send(CMD_CONSUME, 0, 0, 1600, 1600, 0);
  endtask

  // one frame: a run of adds around a base point, maybe noise, then a consume
  task automatic random_frame();
    int bx, by, n, r;
    bx = $urandom_range(1048575) - 524288;
    by = $urandom_range(1048575) - 524288;
    r = $urandom_range(99);
    n = (r < 3) ? 66 : $urandom_range(1, 10);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 5)
        send(CMD_ADD, bx, by, $urandom_range(1) ? 0 : 40, $urandom_range(1) ? 0 : 40, 3);
      else if (r < 8)
        send(drm_op_t'($urandom_range(1) ? CMD_MARK : CMD_CLEAR), 0, 0, 0, 0, 0);
      else if (r < 16)
        send(CMD_ADD, $urandom_range(1048575) - 524288, $urandom_range(1048575) - 524288,
             $urandom_range(524287), $urandom_range(524287), $urandom_range(1023));
      else
        send(CMD_ADD, clamp20(bx + $urandom_range(3000)), clamp20(by + $urandom_range(3000)),
             $urandom_range(1, 600), $urandom_range(1, 600),
             ($urandom_range(4) == 0) ? $urandom_range(1023) : $urandom_range(40));
    end
    r = $urandom_range(99);
    send(CMD_CONSUME, clamp20(bx - $urandom_range(500)), clamp20(by - $urandom_range(500)),
         (r < 5) ? 0 : $urandom_range(1, 5000), (r < 8) ? 0 : $urandom_range(1, 5000),
         $urandom_range(1023));
  endtask

  initial begin
    int thr[4];
    int sidle[4];
    int rstall[4];
    int goal;
    thr = '{65536, 0, 49152, 0};
    thr[3] = $urandom_range(65536);
    sidle = '{0, 86, 0, 9};
    rstall = '{0, 0, 86, 9};
    send_idle_pct = 0;
    stall_pct = 0;
    items_sent = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset threshold first, directed set with no idling
    directed_items();
    drain();
    goal = 0;
    for (int p = 0; p < 4; p++) begin
      write_threshold(thr[p]);
      send_idle_pct = sidle[p];
      stall_pct = rstall[p];
      goal += 35;
      while (items_sent < goal + 20) begin
        random_frame();
        // in phase 1, past the goal, the sender waits for each frame to drain fully
        if (p == 1 && items_sent > goal) drain();
      end
      drain();
    end
    write_threshold(thr[3] ^ 17'h1ffff);
    write_threshold(32768);
    stall_pct = 0;
    random_frame();
    drain();

    $display("sent %0d input transfers over 4 idle/stall mixes and 6 threshold settings",
             items_sent);
    $display("checked %0d result transfers, %0d mismatches", results_seen, fail_count);
    if (fail_count == 0)
      $display("dirty_rect_merge_tracker verification clean");
    else
      $display("dirty_rect_merge_tracker verification failed");
    $finish;
  end

endmodule

### sim.f
hdl/drm_pkg.sv
hdl/drm_ram.sv
hdl/drm_ctrl.sv
hdl/drm_dp.sv
hdl/dirty_rect_merge_tracker.sv
dv/drm_checker.sv
dv/dirty_rect_merge_tracker_tb.sv
